FILE: rtl/sbct_pkg.sv
// Shared types, constants and arithmetic helpers for the segment box clip test.
package sbct_pkg;

  localparam int CoordW      = 32;
  localparam int FracBits    = 16;
  localparam int RatioW      = FracBits + 2;
  localparam int StepsPerStg = 2;
  localparam int DivStages   = FracBits / StepsPerStg;
  localparam int NumPlanes   = 6;
  localparam int NumStages   = DivStages + 4;
  localparam int CfgIdxW     = 3;

  localparam logic [CfgIdxW-1:0] CfgMinX = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxX = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgMinY = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgMaxY = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgMinZ = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgMaxZ = CfgIdxW'(5);

  localparam logic [RatioW-1:0] ParamOne = RatioW'(1) << FracBits;
  localparam logic [RatioW-1:0] ParamAbove = ParamOne + RatioW'(1);
  localparam logic [RatioW-1:0] ParamBelow = '1;

  // One plane after the exact differences: direction p and distance q.
  typedef struct packed {
    logic              pneg;
    logic [CoordW-1:0] pmag;
    logic              qneg;
    logic [CoordW-1:0] qmag;
  } df_t;

  // One plane while its ratio is being divided out.
  typedef struct packed {
    logic                ent;
    logic                par;
    logic                rej;
    logic                spec;
    logic [RatioW-1:0]   sr;
    logic [CoordW-1:0]   den;
    logic [CoordW-1:0]   rem;
    logic [FracBits-1:0] quo;
  } pl_t;

  // Running clip interval.
  typedef struct packed {
    logic              ok;
    logic [RatioW-1:0] u1;
    logic [RatioW-1:0] u2;
  } acc_t;

  function automatic logic [CoordW:0] sdiff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    sdiff = {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

  function automatic logic [CoordW-1:0] mag_of(logic [CoordW:0] d);
    logic [CoordW:0] n;
    n = -d;
    mag_of = d[CoordW] ? n[CoordW-1:0] : d[CoordW-1:0];
  endfunction

  function automatic pl_t classify(df_t d);
    pl_t p;
    p.ent  = d.pneg;
    p.par  = (d.pmag == '0);
    p.rej  = d.qneg;
    p.spec = 1'b1;
    p.sr   = '0;
    p.den  = d.pmag;
    p.rem  = d.qmag;
    p.quo  = '0;
    if (d.qmag == '0) begin
      p.sr = '0;
    end else if (d.qneg != d.pneg) begin
      p.sr = ParamBelow;
    end else if (d.qmag > d.pmag) begin
      p.sr = ParamAbove;
    end else if (d.qmag == d.pmag) begin
      p.sr = ParamOne;
    end else begin
      p.spec = 1'b0;
    end
    return p;
  endfunction

  // One quotient bit of rem / den, rem kept below den.
  function automatic pl_t div_step(pl_t p);
    logic [CoordW:0] t;
    logic [CoordW:0] s;
    pl_t r;
    r = p;
    t = {p.rem, 1'b0};
    s = t - {1'b0, p.den};
    if (t >= {1'b0, p.den}) begin
      r.rem = s[CoordW-1:0];
      r.quo = {p.quo[FracBits-2:0], 1'b1};
    end else begin
      r.rem = t[CoordW-1:0];
      r.quo = {p.quo[FracBits-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic acc_t apply(acc_t a, pl_t p);
    acc_t r;
    logic [RatioW-1:0] q;
    r = a;
    q = p.spec ? p.sr : RatioW'(p.quo);
    if (a.ok) begin
      if (p.par) begin
        if (p.rej) r.ok = 1'b0;
      end else if (p.ent) begin
        if ($signed(q) > $signed(a.u2)) r.ok = 1'b0;
        else if ($signed(q) > $signed(a.u1)) r.u1 = q;
      end else begin
        if ($signed(q) < $signed(a.u1)) r.ok = 1'b0;
        else if ($signed(q) < $signed(a.u2)) r.u2 = q;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/segment_box_clip_test.sv
// Top level of the segment box clip test: a pipelined 3-D Liang-Barsky clipper.
//
// One segment word enters per cycle while the pipe is not held, and its
// result word passes sbct_pkg::NumStages stages: one forms the exact plane
// differences, one sorts out the special ratios, eight each resolve two
// quotient bits of the six plane divisions, and two fold the plane tests in
// order X-, X+, Y-, Y+, Z-, Z+ into the entry/exit interval. The whole pipe
// advances together; it holds only while a finished word sits on the output
// and the sink stalls it. A rejected segment gives hit 0 and both parameters
// 0. Write the box corners only while the pipe is empty; swapped corners on
// an axis are used in sorted order.
module segment_box_clip_test (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sbct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sbct_pkg::CoordW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sbct_pkg::CoordW-1:0]      start_x_i,
  input  logic [sbct_pkg::CoordW-1:0]      start_y_i,
  input  logic [sbct_pkg::CoordW-1:0]      start_z_i,
  input  logic [sbct_pkg::CoordW-1:0]      end_x_i,
  input  logic [sbct_pkg::CoordW-1:0]      end_y_i,
  input  logic [sbct_pkg::CoordW-1:0]      end_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [sbct_pkg::FracBits:0]      enter_param_o,
  output logic [sbct_pkg::FracBits:0]      exit_param_o
);

  localparam int W  = sbct_pkg::CoordW;
  localparam int NS = sbct_pkg::NumStages;
  localparam int DS = sbct_pkg::DivStages;

  // Box corner registers.
  logic [W-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
      min_z_q <= '0;
      max_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbct_pkg::CfgMinX: min_x_q <= cfg_wdata_i;
        sbct_pkg::CfgMaxX: max_x_q <= cfg_wdata_i;
        sbct_pkg::CfgMinY: min_y_q <= cfg_wdata_i;
        sbct_pkg::CfgMaxY: max_y_q <= cfg_wdata_i;
        sbct_pkg::CfgMinZ: min_z_q <= cfg_wdata_i;
        sbct_pkg::CfgMaxZ: max_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sort the corners per axis; the user must keep them static while items flow, as the block does not enforce it.
  logic [W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic         sw_x, sw_y, sw_z;

  assign sw_x = $signed(min_x_q) > $signed(max_x_q);
  assign sw_y = $signed(min_y_q) > $signed(max_y_q);
  assign sw_z = $signed(min_z_q) > $signed(max_z_q);
  assign lo_x = sw_x ? max_x_q : min_x_q;
  assign hi_x = sw_x ? min_x_q : max_x_q;
  assign lo_y = sw_y ? max_y_q : min_y_q;
  assign hi_y = sw_y ? min_y_q : max_y_q;
  assign lo_z = sw_z ? max_z_q : min_z_q;
  assign hi_z = sw_z ? min_z_q : max_z_q;

  // Pipe control: advance everything unless the output word is held.
  logic          adv;
  logic [NS-1:0] v_q;

  assign adv         = !(v_q[NS-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 1: exact direction and plane distances.
  logic [W:0] d_x, d_y, d_z, qa_x, qb_x, qa_y, qb_y, qa_z, qb_z;
  sbct_pkg::df_t df_d [sbct_pkg::NumPlanes];
  sbct_pkg::df_t df_q [sbct_pkg::NumPlanes];

  assign d_x  = sbct_pkg::sdiff(end_x_i, start_x_i);
  assign d_y  = sbct_pkg::sdiff(end_y_i, start_y_i);
  assign d_z  = sbct_pkg::sdiff(end_z_i, start_z_i);
  assign qa_x = sbct_pkg::sdiff(start_x_i, lo_x);
  assign qb_x = sbct_pkg::sdiff(hi_x, start_x_i);
  assign qa_y = sbct_pkg::sdiff(start_y_i, lo_y);
  assign qb_y = sbct_pkg::sdiff(hi_y, start_y_i);
  assign qa_z = sbct_pkg::sdiff(start_z_i, lo_z);
  assign qb_z = sbct_pkg::sdiff(hi_z, start_z_i);

  always_comb begin
    // Lower planes use -d; the sign of a zero p is never looked at.
    df_d[0] = '{pneg: !d_x[W], pmag: sbct_pkg::mag_of(d_x),
                qneg: qa_x[W], qmag: sbct_pkg::mag_of(qa_x)};
    df_d[1] = '{pneg: d_x[W],  pmag: sbct_pkg::mag_of(d_x),
                qneg: qb_x[W], qmag: sbct_pkg::mag_of(qb_x)};
    df_d[2] = '{pneg: !d_y[W], pmag: sbct_pkg::mag_of(d_y),
                qneg: qa_y[W], qmag: sbct_pkg::mag_of(qa_y)};
    df_d[3] = '{pneg: d_y[W],  pmag: sbct_pkg::mag_of(d_y),
                qneg: qb_y[W], qmag: sbct_pkg::mag_of(qb_y)};
    df_d[4] = '{pneg: !d_z[W], pmag: sbct_pkg::mag_of(d_z),
                qneg: qa_z[W], qmag: sbct_pkg::mag_of(qa_z)};
    df_d[5] = '{pneg: d_z[W],  pmag: sbct_pkg::mag_of(d_z),
                qneg: qb_z[W], qmag: sbct_pkg::mag_of(qb_z)};
  end

  // Stage 2 and the divider stages.
  sbct_pkg::pl_t pl_q [DS+1][sbct_pkg::NumPlanes];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < sbct_pkg::NumPlanes; i++) begin
        df_q[i]    <= df_d[i];
        pl_q[0][i] <= sbct_pkg::classify(df_q[i]);
      end
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < sbct_pkg::NumPlanes; i++) begin
          pl_q[k][i] <= sbct_pkg::div_step(sbct_pkg::div_step(pl_q[k-1][i]));
        end
      end
    end
  end

  // Fold the plane tests: X planes and Y- first, then the rest.
  sbct_pkg::acc_t acc_init, c1_d, c1_q, c2_d;
  sbct_pkg::pl_t  tail_q [3];
  logic                     hit_q;
  logic [sbct_pkg::FracBits:0] enter_q, exit_q;

  always_comb begin
    acc_init = '{ok: 1'b1, u1: '0, u2: sbct_pkg::ParamOne};
    c1_d = sbct_pkg::apply(acc_init, pl_q[DS][0]);
    c1_d = sbct_pkg::apply(c1_d, pl_q[DS][1]);
    c1_d = sbct_pkg::apply(c1_d, pl_q[DS][2]);
    c2_d = sbct_pkg::apply(c1_q, tail_q[0]);
    c2_d = sbct_pkg::apply(c2_d, tail_q[1]);
    c2_d = sbct_pkg::apply(c2_d, tail_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q      <= c1_d;
      tail_q[0] <= pl_q[DS][3];
      tail_q[1] <= pl_q[DS][4];
      tail_q[2] <= pl_q[DS][5];
      hit_q     <= c2_d.ok;
      enter_q   <= c2_d.ok ? c2_d.u1[sbct_pkg::FracBits:0] : '0;
      exit_q    <= c2_d.ok ? c2_d.u2[sbct_pkg::FracBits:0] : '0;
    end
  end

  assign hit_o         = hit_q;
  assign enter_param_o = enter_q;
  assign exit_param_o  = exit_q;

endmodule

FILE: rtl/sbct_checker.sv
// Port-level checker for the segment box clip test, bound to the top level.
module sbct_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        hit_o,
  input logic [sbct_pkg::FracBits:0] enter_param_o,
  input logic [sbct_pkg::FracBits:0] exit_param_o
);

  localparam logic [sbct_pkg::FracBits:0] One = (sbct_pkg::FracBits+1)'(1) << sbct_pkg::FracBits;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> enter_param_o == '0 && exit_param_o == '0)
    else $error("rejected word carries nonzero parameters");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> enter_param_o <= exit_param_o)
    else $error("entry parameter beyond exit parameter");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> exit_param_o <= One && enter_param_o <= One)
    else $error("parameter above one");

endmodule

bind segment_box_clip_test sbct_checker u_sbct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .hit_o        (hit_o),
  .enter_param_o(enter_param_o),
  .exit_param_o (exit_param_o)
);

FILE: test/tb_top.sv
// Self-checking bench for the pipelined segment against box clipping test.
`timescale 1ns / 1ps

module tb_top;

  localparam longint Unit = 64'sd65536;

  // One segment word as it goes onto the input port.
  typedef struct packed {
    logic [sbct_pkg::CoordW-1:0] sx;
    logic [sbct_pkg::CoordW-1:0] sy;
    logic [sbct_pkg::CoordW-1:0] sz;
    logic [sbct_pkg::CoordW-1:0] ex;
    logic [sbct_pkg::CoordW-1:0] ey;
    logic [sbct_pkg::CoordW-1:0] ez;
  } segment_t;

  // One clip result word.
  typedef struct packed {
    logic                        hit;
    logic [sbct_pkg::FracBits:0] enter;
    logic [sbct_pkg::FracBits:0] leave;
  } clip_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sbct_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [sbct_pkg::CoordW-1:0]   cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [sbct_pkg::CoordW-1:0]   start_x_i, start_y_i, start_z_i;
  logic [sbct_pkg::CoordW-1:0]   end_x_i, end_y_i, end_z_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          hit_o;
  logic [sbct_pkg::FracBits:0]   enter_param_o;
  logic [sbct_pkg::FracBits:0]   exit_param_o;

  segment_box_clip_test dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .enter_param_o(enter_param_o),
    .exit_param_o (exit_param_o)
  );

  // Clock: 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  segment_t segs_pending[$];
  clip_t    clips_due[$];
  longint   box[6];        // bench copy of the corner registers, sign-extended
  bit       no_idle;       // when set, neither side idles
  int       errors;
  int       words_in;
  int       words_out;
  int       hits_seen;
  int       phases_run;

  // ---------------------------------------------------------------------------
  // Clipping arithmetic, worked out with 64-bit signed integers, which hold
  // every 33-bit difference exactly.
  // ---------------------------------------------------------------------------

  // q/p as Q1.16, with minus one lsb below zero and one plus one lsb above one.
  function automatic longint plane_ratio(longint p, longint q);
    longint den, rem, quo, gap;
    den = (p < 0) ? -p : p;
    rem = (q < 0) ? -q : q;
    quo = 0;
    if (q == 0) return 0;
    if ((q < 0) != (p < 0)) return -1;
    if (rem > den) return Unit + 1;
    if (rem == den) return Unit;
    for (int i = 0; i < sbct_pkg::FracBits; i++) begin
      gap = den - rem;
      quo = quo << 1;
      if (rem >= gap) begin
        rem = rem - gap;
        quo = quo | 1;
      end else begin
        rem = rem + rem;
      end
    end
    return quo;
  endfunction

  // One plane: narrow the interval, or return 0 to reject.
  function automatic bit narrow(longint p, longint q, inout longint u1, inout longint u2);
    longint r;
    if (p == 0) return !(q < 0);
    r = plane_ratio(p, q);
    if (p < 0) begin
      if (r > u2) return 0;
      if (r > u1) u1 = r;
    end else begin
      if (r < u1) return 0;
      if (r < u2) u2 = r;
    end
    return 1;
  endfunction

  // Lower then upper plane of one axis; corners taken in sorted order.
  function automatic bit clip_axis(logic [sbct_pkg::CoordW-1:0] s_raw,
                                   logic [sbct_pkg::CoordW-1:0] e_raw,
                                   longint ca, longint cb,
                                   inout longint u1, inout longint u2);
    longint s, e, lo, hi;
    s  = longint'($signed(s_raw));
    e  = longint'($signed(e_raw));
    lo = (ca > cb) ? cb : ca;
    hi = (ca > cb) ? ca : cb;
    if (!narrow(s - e, s - lo, u1, u2)) return 0;
    return narrow(e - s, hi - s, u1, u2);
  endfunction

  function automatic clip_t clip_segment(segment_t g);
    clip_t  c;
    longint u1, u2;
    bit     ok;
    u1 = 0;
    u2 = Unit;
    ok = clip_axis(g.sx, g.ex, box[0], box[1], u1, u2) &&
         clip_axis(g.sy, g.ey, box[2], box[3], u1, u2) &&
         clip_axis(g.sz, g.ez, box[4], box[5], u1, u2);
    c.hit   = ok;
    c.enter = ok ? u1[sbct_pkg::FracBits:0] : '0;
    c.leave = ok ? u2[sbct_pkg::FracBits:0] : '0;
    return c;
  endfunction

  task automatic report(string what, clip_t got, clip_t want);
    errors++;
    $display("[%0t] %s: got hit %0b u1 %0d u2 %0d, want hit %0b u1 %0d u2 %0d",
             $time, what, got.hit, got.enter, got.leave, want.hit, want.enter, want.leave);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued words, holding each one while the block stalls it,
  // and record the predicted result the moment a word is taken.
  // ---------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t g;
    logic     next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      start_x_i  <= '0;
      start_y_i  <= '0;
      start_z_i  <= '0;
      end_x_i    <= '0;
      end_y_i    <= '0;
      end_z_i    <= '0;
      send_gap   = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        clips_due.push_back(clip_segment({start_x_i, start_y_i, start_z_i,
                                          end_x_i, end_y_i, end_z_i}));
        words_in++;
        next_valid = 1'b0;
        send_gap = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (segs_pending.size() > 0) begin
          g = segs_pending.pop_front();
          start_x_i <= g.sx;
          start_y_i <= g.sy;
          start_z_i <= g.sz;
          end_x_i   <= g.ex;
          end_y_i   <= g.ey;
          end_z_i   <= g.ez;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the output at random and check each word taken against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  int sink_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    clip_t got;
    clip_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_wait   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {hit_o, enter_param_o, exit_param_o};
        words_out++;
        if (hit_o) hits_seen++;
        if (clips_due.size() == 0) begin
          report("result with none expected", got, '0);
        end else begin
          want = clips_due.pop_front();
          if (got.hit !== want.hit) report("hit mismatch", got, want);
          else if (got.enter !== want.enter) report("entry mismatch", got, want);
          else if (got.leave !== want.leave) report("exit mismatch", got, want);
        end
        sink_wait = no_idle ? 0 : $urandom_range(0, 13);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      out_stall_i <= (sink_wait != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [sbct_pkg::CoordW-1:0] fx(int n);
    return sbct_pkg::CoordW'(longint'(n) * Unit);
  endfunction

  function automatic segment_t seg(logic [sbct_pkg::CoordW-1:0] sx,
                                   logic [sbct_pkg::CoordW-1:0] sy,
                                   logic [sbct_pkg::CoordW-1:0] sz,
                                   logic [sbct_pkg::CoordW-1:0] ex,
                                   logic [sbct_pkg::CoordW-1:0] ey,
                                   logic [sbct_pkg::CoordW-1:0] ez);
    return {sx, sy, sz, ex, ey, ez};
  endfunction

  // Write one corner register and update the bench copy.
  task automatic write_corner(logic [sbct_pkg::CfgIdxW-1:0] idx,
                              logic [sbct_pkg::CoordW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box[idx] = longint'($signed(val));
  endtask

  task automatic set_box(logic [sbct_pkg::CoordW-1:0] x0, logic [sbct_pkg::CoordW-1:0] x1,
                         logic [sbct_pkg::CoordW-1:0] y0, logic [sbct_pkg::CoordW-1:0] y1,
                         logic [sbct_pkg::CoordW-1:0] z0, logic [sbct_pkg::CoordW-1:0] z1);
    write_corner(sbct_pkg::CfgMinX, x0);
    write_corner(sbct_pkg::CfgMaxX, x1);
    write_corner(sbct_pkg::CfgMinY, y0);
    write_corner(sbct_pkg::CfgMaxY, y1);
    write_corner(sbct_pkg::CfgMinZ, z0);
    write_corner(sbct_pkg::CfgMaxZ, z1);
  endtask

  // Hold until every queued word has gone in and every result has come out,
  // then let the pipe run dry. Look on the falling edge, once the driver has
  // settled what it presents.
  task automatic drain;
    while (segs_pending.size() > 0 || in_valid_i || clips_due.size() > 0)
      @(negedge clk_i);
    repeat (sbct_pkg::NumStages + 4) @(posedge clk_i);
    phases_run++;
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // A coordinate near the box span on one axis, so most planes actually cut.
  function automatic logic [sbct_pkg::CoordW-1:0] near_axis(longint ca, longint cb);
    longint lo, span, v;
    lo   = (ca < cb) ? ca : cb;
    span = ((ca < cb) ? cb - ca : ca - cb) + 1;
    v    = lo - span / 2 + longint'({$urandom, $urandom} % (2 * span + 1));
    // Now and then land exactly on a face.
    case ($urandom_range(0, 9))
      0: v = ca;
      1: v = cb;
      default: ;
    endcase
    return sbct_pkg::CoordW'(clamp_coord(v));
  endfunction

  function automatic segment_t random_segment;
    segment_t g;
    case ($urandom_range(0, 7))
      0: g = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      1: begin
        // Axis-parallel on some axis: copy start into end there.
        g = {near_axis(box[0], box[1]), near_axis(box[2], box[3]),
             near_axis(box[4], box[5]), near_axis(box[0], box[1]),
             near_axis(box[2], box[3]), near_axis(box[4], box[5])};
        case ($urandom_range(0, 2))
          0: g.ex = g.sx;
          1: g.ey = g.sy;
          default: g.ez = g.sz;
        endcase
      end
      default:
        g = {near_axis(box[0], box[1]), near_axis(box[2], box[3]),
             near_axis(box[4], box[5]), near_axis(box[0], box[1]),
             near_axis(box[2], box[3]), near_axis(box[4], box[5])};
    endcase
    return g;
  endfunction

  // A random box: mostly modest, sometimes with swapped corners.
  task automatic random_box;
    logic [sbct_pkg::CoordW-1:0] c[6];
    int  centre, half;
    for (int a = 0; a < 3; a++) begin
      centre = $urandom_range(0, 2000) - 1000;
      half   = $urandom_range(0, 400);
      c[2*a]     = sbct_pkg::CoordW'(longint'(centre - half) * Unit / 4
                                     + $urandom_range(0, 65535));
      c[2*a + 1] = sbct_pkg::CoordW'(longint'(centre + half) * Unit / 4
                                     + $urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) begin
        c[2*a]     ^= c[2*a + 1];
        c[2*a + 1] ^= c[2*a];
        c[2*a]     ^= c[2*a + 1];
      end
    end
    set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  localparam logic [sbct_pkg::CoordW-1:0] CoordMin = {1'b1, {(sbct_pkg::CoordW-1){1'b0}}};
  localparam logic [sbct_pkg::CoordW-1:0] CoordMax = {1'b0, {(sbct_pkg::CoordW-1){1'b1}}};

  initial begin
    errors      = 0;
    words_in    = 0;
    words_out   = 0;
    hits_seen   = 0;
    phases_run  = 0;
    no_idle     = 1'b0;
    for (int i = 0; i < 6; i++) box[i] = 0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = sbct_pkg::CfgMinX;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b0;
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Box left at reset: a single point at the origin.
    segs_pending.push_back(seg(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1)));
    segs_pending.push_back(seg('0, '0, '0, '0, '0, '0));  // point on the box
    segs_pending.push_back(seg(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    segs_pending.push_back(seg(fx(1), fx(1), fx(1), fx(2), fx(2), fx(2)));
    drain();

    // Box of plus or minus ten units.
    set_box(fx(-10), fx(10), fx(-10), fx(10), fx(-10), fx(10));
    segs_pending.push_back(seg(fx(-1), fx(-2), fx(-3), fx(4), fx(5), fx(6)));   // inside
    segs_pending.push_back(seg(fx(-20), 0, 0, fx(20), 0, 0));                  // crosses
    segs_pending.push_back(seg(fx(20), fx(1), 0, fx(-20), fx(2), fx(3)));      // reversed
    segs_pending.push_back(seg(fx(11), fx(11), fx(11), fx(30), fx(40), fx(50))); // outside
    segs_pending.push_back(seg(fx(12), fx(-5), 0, fx(12), fx(5), 0));          // parallel, out
    segs_pending.push_back(seg(fx(10), fx(-5), 0, fx(10), fx(5), 0));          // on a face
    segs_pending.push_back(seg(0, 0, 0, fx(10), 0, 0));                        // ends on face
    segs_pending.push_back(seg(fx(-10), 0, 0, fx(-30), 0, 0));                 // starts on face
    segs_pending.push_back(seg(fx(-30), 0, 0, fx(30), fx(60), 0));             // misses a corner
    segs_pending.push_back(seg(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax));
    segs_pending.push_back(seg(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
    segs_pending.push_back(seg(0, 0, 0, 32'sd1, 0, 0));                        // tiny step
    segs_pending.push_back(seg(fx(-10) - 1, 0, 0, fx(10) + 1, 0, 0));          // just outside
    drain();

    // Box of ten, seven and three units about the origin, every axis's corners swapped.
    set_box(fx(10), fx(-10), fx(7), fx(-7), fx(3), fx(-3));
    segs_pending.push_back(seg(fx(-20), fx(-20), fx(-20), fx(20), fx(20), fx(20)));
    segs_pending.push_back(seg(0, fx(8), 0, fx(5), fx(8), 0));
    segs_pending.push_back(seg(fx(1), fx(1), fx(1), fx(2), fx(2), fx(9)));
    drain();

    // Widest box the registers hold, and a box of zero extent on X and Z.
    set_box(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax);
    segs_pending.push_back(seg(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    for (int i = 0; i < 60; i++) segs_pending.push_back(random_segment());
    drain();
    set_box(fx(2), fx(2), fx(-4), fx(4), CoordMax, CoordMax);
    for (int i = 0; i < 60; i++) segs_pending.push_back(random_segment());
    drain();

    // Random boxes; at least one phase runs with neither side idling.
    for (int ph = 0; ph < 7; ph++) begin
      random_box();
      no_idle = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 180; i++) segs_pending.push_back(random_segment());
      drain();
    end
    no_idle = 1'b0;

    // Anything still expected now was lost by the block.
    while (clips_due.size() > 0) report("result never came", '0, clips_due.pop_front());

    $display("Covered %0d segments over %0d box settings; %0d hit, %0d rejected.",
             words_in, phases_run, hits_seen, words_out - hits_seen);
    $display("Both sides idled at random, with bursts at full rate; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
